// File: rtl/mnrf_pkg.sv
package mnrf_pkg;

    // sizes of the note table
    localparam int NOTE_COUNT      = 128;
    localparam int CHANNEL_COUNT   = 16;
    localparam int MAX_FOLD_ROUNDS = 128;

    localparam int NOTE_W    = 7;
    localparam int STATUS_W  = 8;
    localparam int SHIFT_W   = 8;
    localparam int CHAN_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int ADDR_W    = NOTE_W + CHAN_W;
    localparam int MEM_DEPTH = NOTE_COUNT << CHAN_W;

    // fold arithmetic: start note plus growth of up to two range widths per round
    localparam int FOLD_W  = $clog2((2 * MAX_FOLD_ROUNDS + 2) * NOTE_COUNT) + 1;
    localparam int ROUND_W = $clog2(MAX_FOLD_ROUNDS + 1);

    // message types, upper nibble of the status byte
    localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
    localparam logic [3:0] MSG_POLY_PRESS = 4'hA;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_NOTE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_NOTE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_SHIFT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_ON    = 2'd3;

endpackage

// File: rtl/midi_note_range_folder.sv
// MIDI note range folder
// Input channel: one three-byte MIDI message per request, i_valid / o_stall.
// Output channel: zero or one message per input request, o_valid / i_stall.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 top note,
// 1 bottom note, 2 signed pre-shift, 3 power on; the user must write these
// only while idle, as the block does not enforce it. One message is processed
// at a time. With power on and distinct bounds, note-on and poly-pressure
// notes are shifted and reflected between the bounds, one round per cycle.
// Note-off reads the per note/channel table (a single synchronous RAM). A
// message whose fold has not settled within MAX_FOLD_ROUNDS - 1 rounds gives
// no output.
// Reset: a clearing pass writes every table entry with its own note number,
// one entry a cycle over all MEM_DEPTH (2048) entries; o_stall stays high meanwhile.
// The result waits in an output register while i_stall is high; the next
// message is accepted meanwhile, and its result leaves once the register frees.
module midi_note_range_folder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [mnrf_pkg::STATUS_W-1:0]        i_status_byte,
    input  logic [mnrf_pkg::NOTE_W-1:0]          i_first_data,
    input  logic [mnrf_pkg::NOTE_W-1:0]          i_second_data,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [mnrf_pkg::STATUS_W-1:0]        o_out_status,
    output logic [mnrf_pkg::NOTE_W-1:0]          o_out_first_data,
    output logic [mnrf_pkg::NOTE_W-1:0]          o_out_second_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mnrf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mnrf_pkg::SHIFT_W-1:0]         i_cfg_data
);
    import mnrf_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RECALL,
        S_FOLD,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [NOTE_W-1:0]  r_top, n_top;
    logic [NOTE_W-1:0]  r_bottom, n_bottom;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic               r_power, n_power;

    // message under work
    logic [STATUS_W-1:0]      r_status, n_status;
    logic [NOTE_W-1:0]        r_d1, n_d1;
    logic [NOTE_W-1:0]        r_d2, n_d2;
    logic [NOTE_W-1:0]        r_note, n_note;
    logic                     r_keep, n_keep;
    logic                     r_store, n_store;
    logic signed [FOLD_W-1:0] r_n, n_n;
    logic [ROUND_W-1:0]       r_rounds, n_rounds;
    logic [ADDR_W-1:0]        r_clr, n_clr;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [NOTE_W-1:0]   r_out_d1, n_out_d1;
    logic [NOTE_W-1:0]   r_out_d2, n_out_d2;

    // note table
    logic [NOTE_W-1:0] note_mem [0:MEM_DEPTH-1];
    logic [NOTE_W-1:0] r_rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [NOTE_W-1:0] mem_wdata;

    // input decode
    logic              in_accept;
    logic [3:0]        in_kind;
    logic              in_note_on;
    logic              in_note_off;
    logic              in_chan_ok;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] done_addr;
    logic              out_free;

    // fold unit
    logic signed [FOLD_W-1:0] hi_x, lo_x, start_n, refl_hi, refl_lo, fold_next;
    logic                     in_range;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign in_accept   = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;

    assign in_kind     = i_status_byte[STATUS_W-1 -: 4];
    assign in_note_on  = (in_kind == MSG_NOTE_ON) && (i_second_data != '0);
    assign in_note_off = (in_kind == MSG_NOTE_OFF) ||
                         ((in_kind == MSG_NOTE_ON) && (i_second_data == '0));
    assign in_chan_ok  = ({1'b0, i_status_byte[3:0]} < 5'(CHANNEL_COUNT));
    assign in_addr     = {i_first_data, i_status_byte[CHAN_W-1:0]};
    assign done_addr   = {r_d1, r_status[CHAN_W-1:0]};

    // one reflection round: about the top, then about the bottom if below it
    assign hi_x      = $signed({{(FOLD_W-NOTE_W){1'b0}}, r_top});
    assign lo_x      = $signed({{(FOLD_W-NOTE_W){1'b0}}, r_bottom});
    assign start_n   = $signed({{(FOLD_W-NOTE_W){1'b0}}, i_first_data}) +
                       $signed({{(FOLD_W-SHIFT_W){r_shift[SHIFT_W-1]}}, r_shift});
    assign in_range  = (r_n <= hi_x) && (r_n >= lo_x);
    assign refl_hi   = (hi_x <<< 1) - r_n;
    assign refl_lo   = (lo_x <<< 1) - refl_hi;
    assign fold_next = (refl_hi < lo_x) ? refl_lo : refl_hi;

    // table write port: clearing pass, note-off reset, note-on store
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = in_addr;
        mem_wdata = i_first_data;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = r_clr[ADDR_W-1 -: NOTE_W];
        end else if (r_state == S_DONE) begin
            mem_we    = out_free && r_store;
            mem_waddr = done_addr;
            mem_wdata = r_note;
        end else if (in_accept && in_note_off && in_chan_ok) begin
            mem_we    = 1'b1;
        end
    end

    // note table, read before write
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            note_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= note_mem[in_addr];
    end

    // next state
    always_comb begin
        n_state      = r_state;
        n_top        = r_top;
        n_bottom     = r_bottom;
        n_shift      = r_shift;
        n_power      = r_power;
        n_status     = r_status;
        n_d1         = r_d1;
        n_d2         = r_d2;
        n_note       = r_note;
        n_keep       = r_keep;
        n_store      = r_store;
        n_n          = r_n;
        n_rounds     = r_rounds;
        n_clr        = r_clr;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_d1     = r_out_d1;
        n_out_d2     = r_out_d2;

        // configuration writes
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TOP_NOTE:    n_top    = i_cfg_data[NOTE_W-1:0];
                REG_BOTTOM_NOTE: n_bottom = i_cfg_data[NOTE_W-1:0];
                REG_PRE_SHIFT:   n_shift  = i_cfg_data;
                REG_POWER_ON:    n_power  = i_cfg_data[0];
                default:         ;
            endcase
        end

        // output register drains
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == ADDR_W'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_status = i_status_byte;
                    n_d1     = i_first_data;
                    n_d2     = i_second_data;
                    n_note   = i_first_data;
                    n_keep   = 1'b1;
                    n_store  = in_note_on && in_chan_ok;
                    n_state  = S_DONE;
                    if (in_note_on || (in_kind == MSG_POLY_PRESS)) begin
                        if (r_power) begin
                            if (r_top == r_bottom) begin
                                n_note = r_bottom;
                            end else begin
                                n_n      = start_n;
                                n_rounds = '0;
                                n_state  = S_FOLD;
                            end
                        end
                    end else if (in_note_off && in_chan_ok) begin
                        n_state = S_RECALL;
                    end
                end
            end
            S_RECALL: begin
                n_note  = r_rd_data;
                n_state = S_DONE;
            end
            S_FOLD: begin
                if (in_range) begin
                    n_note  = r_n[NOTE_W-1:0];
                    n_state = S_DONE;
                end else begin
                    n_n      = fold_next;
                    n_rounds = r_rounds + 1'b1;
                    if (r_rounds == ROUND_W'(MAX_FOLD_ROUNDS - 1)) begin
                        n_keep  = 1'b0;
                        n_note  = fold_next[NOTE_W-1:0];
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    if (r_keep) begin
                        n_out_valid  = 1'b1;
                        n_out_status = r_status;
                        n_out_d1     = r_note;
                        n_out_d2     = r_d2;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_top       <= NOTE_W'(NOTE_COUNT - 1);
            r_bottom    <= '0;
            r_shift     <= '0;
            r_power     <= 1'b1;
            r_out_valid <= 1'b0;
            r_keep      <= 1'b0;
            r_store     <= 1'b0;
            r_rounds    <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_top       <= n_top;
            r_bottom    <= n_bottom;
            r_shift     <= n_shift;
            r_power     <= n_power;
            r_out_valid <= n_out_valid;
            r_keep      <= n_keep;
            r_store     <= n_store;
            r_rounds    <= n_rounds;
        end
        r_status     <= n_status;
        r_d1         <= n_d1;
        r_d2         <= n_d2;
        r_note       <= n_note;
        r_n          <= n_n;
        r_out_status <= n_out_status;
        r_out_d1     <= n_out_d1;
        r_out_d2     <= n_out_d2;
    end

    assign o_valid           = r_out_valid;
    assign o_out_status      = r_out_status;
    assign o_out_first_data  = r_out_d1;
    assign o_out_second_data = r_out_d2;

    // no result leaves while the table is being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_valid)
        else $error("output valid during clearing pass");

    // an accepted request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("accepted request did not start work");

    // the fold never runs past its round limit
    a_round_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |-> (r_rounds < ROUND_W'(MAX_FOLD_ROUNDS)))
        else $error("fold round counter past limit");

    // a settled fold leaves a note inside the bounds
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FOLD) && in_range) |=> ((r_note <= r_top) && (r_note >= r_bottom)))
        else $error("settled note outside bounds");

endmodule

// File: dv/tb_top.sv
module tb_top;
    import mnrf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = MAX_FOLD_ROUNDS + 8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NOTE_W-1:0]   first;
        logic [NOTE_W-1:0]   second;
    } t_midi_msg;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // block ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [STATUS_W-1:0]  i_status_byte = '0;
    logic [NOTE_W-1:0]    i_first_data = '0;
    logic [NOTE_W-1:0]    i_second_data = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [STATUS_W-1:0]  o_out_status;
    logic [NOTE_W-1:0]    o_out_first_data;
    logic [NOTE_W-1:0]    o_out_second_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SHIFT_W-1:0]   i_cfg_data = '0;

    // predictor state
    logic [NOTE_W-1:0]         cfg_top = 7'd127;
    logic [NOTE_W-1:0]         cfg_bottom = 7'd0;
    logic signed [SHIFT_W-1:0] cfg_shift = 8'sd0;
    logic                      cfg_power = 1'b1;
    logic [NOTE_W-1:0]         key_notes [MEM_DEPTH];

    t_midi_msg   expected_msgs [$];
    logic [10:0] held_keys [$];

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int errors = 0;
    int sent_cnt = 0;
    int checked_cnt = 0;
    int dropped_cnt = 0;
    int settings_cnt = 0;
    int quiet_cycles = 0;

    midi_note_range_folder uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_status_byte     (i_status_byte),
        .i_first_data      (i_first_data),
        .i_second_data     (i_second_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_status      (o_out_status),
        .o_out_first_data  (o_out_first_data),
        .o_out_second_data (o_out_second_data),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // reflect between the bounds one round at a time, fails at the round limit
    function automatic bit fold_into_range(input int start, output int settled);
        int hi;
        int lo;
        int n;
        int rounds;
        bit ok;
        hi = int'(cfg_top);
        lo = int'(cfg_bottom);
        n = start;
        rounds = MAX_FOLD_ROUNDS;
        ok = 1'b1;
        while (n > hi || n < lo) begin
            n = n + 2 * (hi - n);
            if (n < lo)
                n = n - 2 * (n - lo);
            rounds--;
            if (rounds <= 0) begin
                ok = 1'b0;
                break;
            end
        end
        settled = n;
        return ok;
    endfunction

    // expected output message, updates the per key note table
    function automatic bit fold_message(input t_midi_msg msg, output t_midi_msg res);
        logic [3:0]        kind;
        int                chan;
        int                slot;
        int                n;
        int                folded;
        bit                keep;
        bit                key_ok;
        bit                is_on;
        bit                is_off;
        logic [NOTE_W-1:0] note_out;
        kind = msg.status[7:4];
        chan = int'(msg.status[3:0]);
        note_out = msg.first;
        keep = 1'b1;
        key_ok = (chan < CHANNEL_COUNT) && (int'(msg.first) < NOTE_COUNT);
        slot = int'(msg.first) * CHANNEL_COUNT + chan;
        is_on = (kind == MSG_NOTE_ON) && (msg.second != 0);
        is_off = (kind == MSG_NOTE_OFF) || ((kind == MSG_NOTE_ON) && (msg.second == 0));
        if (is_on || kind == MSG_POLY_PRESS) begin
            n = int'(msg.first);
            if (cfg_power) begin
                if (cfg_top == cfg_bottom) begin
                    n = int'(cfg_bottom);
                end else begin
                    keep = fold_into_range(n + int'(cfg_shift), folded);
                    n = folded;
                end
            end
            note_out = n[6:0];
            if (is_on && key_ok)
                key_notes[slot] = note_out;
        end else if (is_off && key_ok) begin
            note_out = key_notes[slot];
            key_notes[slot] = msg.first;
        end
        res = '{msg.status, note_out, msg.second};
        return keep;
    endfunction

    // output side: random stall and result compare
    always @(posedge i_clk) begin : result_check
        t_midi_msg want;
        i_stall <= ($urandom_range(99) < snk_stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_msgs.size() == 0) begin
                $error("unexpected result: status %h first %h second %h",
                       o_out_status, o_out_first_data, o_out_second_data);
                errors++;
            end else begin
                want = expected_msgs.pop_front();
                checked_cnt++;
                if (o_out_status !== want.status) begin
                    $error("out_status mismatch: expected %h, actual %h",
                           want.status, o_out_status);
                    errors++;
                end
                if (o_out_first_data !== want.first) begin
                    $error("out_first_data mismatch: expected %h, actual %h",
                           want.first, o_out_first_data);
                    errors++;
                end
                if (o_out_second_data !== want.second) begin
                    $error("out_second_data mismatch: expected %h, actual %h",
                           want.second, o_out_second_data);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
            end
            IDLE_SENDER: begin
                src_idle_pct = 67;
                snk_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                src_idle_pct = 0;
                snk_stall_pct = 67;
            end
            default: begin
                src_idle_pct = 11;
                snk_stall_pct = 11;
            end
        endcase
    endtask

    // one request on the message channel, with optional idle cycles first
    task automatic send_msg(input logic [7:0] st, input logic [6:0] d1, input logic [6:0] d2);
        t_midi_msg msg;
        t_midi_msg res;
        if ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_status_byte <= st;
        i_first_data <= d1;
        i_second_data <= d2;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        msg = '{st, d1, d2};
        sent_cnt++;
        if (fold_message(msg, res))
            expected_msgs = {expected_msgs, res};
        else
            dropped_cnt++;
    endtask

    // drain results and let a dropped message finish its fold
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_msgs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // write all four registers while idle
    task automatic set_regs(input int top, input int bottom, input int shift, input int pwr);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [7:0]           vals [4];
        idx[0] = REG_TOP_NOTE;
        idx[1] = REG_BOTTOM_NOTE;
        idx[2] = REG_PRE_SHIFT;
        idx[3] = REG_POWER_ON;
        vals[0] = {1'b0, top[6:0]};
        vals[1] = {1'b0, bottom[6:0]};
        vals[2] = shift[7:0];
        vals[3] = {7'b0, pwr[0]};
        settle();
        for (int r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[r];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            case (idx[r])
                REG_TOP_NOTE:    cfg_top = vals[r][6:0];
                REG_BOTTOM_NOTE: cfg_bottom = vals[r][6:0];
                REG_PRE_SHIFT:   cfg_shift = vals[r];
                REG_POWER_ON:    cfg_power = vals[r][0];
                default:         ;
            endcase
        end
        i_cfg_valid <= 1'b0;
        settings_cnt++;
    endtask

    // non-note messages and field extremes under reset settings
    task automatic test_passthrough();
        send_msg(8'h00, 7'd0, 7'd0);
        send_msg(8'hFF, 7'd127, 7'd127);
        send_msg(8'hB5, 7'd7, 7'd100);
        send_msg(8'hF0, 7'h55, 7'h2A);
        send_msg(8'hC3, 7'h2A, 7'h55);
    endtask

    // reset settings: full range, no shift, store and recall
    task automatic test_default_fold();
        send_msg({MSG_NOTE_ON, 4'h0}, 7'd0, 7'd127);
        send_msg({MSG_NOTE_ON, 4'hF}, 7'd127, 7'd1);
        send_msg({MSG_POLY_PRESS, 4'h3}, 7'd64, 7'd55);
        send_msg({MSG_NOTE_OFF, 4'h0}, 7'd0, 7'd0);
        // zero velocity note-on acts as note-off
        send_msg({MSG_NOTE_ON, 4'hF}, 7'd127, 7'd0);
    endtask

    // narrow range with shifts of plus and minus 100
    task automatic test_shift_fold();
        set_regs(72, 60, 100, 1);
        send_msg({MSG_NOTE_ON, 4'h1}, 7'd127, 7'd64);
        send_msg({MSG_POLY_PRESS, 4'h1}, 7'd0, 7'd10);
        send_msg({MSG_NOTE_OFF, 4'h1}, 7'd127, 7'd33);
        set_regs(72, 60, -100, 1);
        send_msg({MSG_NOTE_ON, 4'h2}, 7'd5, 7'd9);
        send_msg({MSG_NOTE_ON, 4'h2}, 7'd5, 7'd0);
    endtask

    // power off passes notes but still stores them
    task automatic test_power_off();
        set_regs(40, 30, 50, 0);
        send_msg({MSG_NOTE_ON, 4'h4}, 7'd100, 7'd70);
        send_msg({MSG_POLY_PRESS, 4'h4}, 7'd3, 7'd3);
        send_msg({MSG_NOTE_OFF, 4'h4}, 7'd100, 7'd0);
    endtask

    // equal bounds force the note to the bound
    task automatic test_equal_bounds();
        set_regs(64, 64, 20, 1);
        send_msg({MSG_NOTE_ON, 4'h5}, 7'd10, 7'd1);
        send_msg({MSG_NOTE_OFF, 4'h5}, 7'd10, 7'd0);
    endtask

    // round limit: settling just past the limit, settling in the last round, never settling
    task automatic test_fold_limit();
        set_regs(127, 126, -128, 1);
        send_msg({MSG_NOTE_ON, 4'h6}, 7'd2, 7'd5);
        send_msg({MSG_NOTE_ON, 4'h6}, 7'd4, 7'd5);
        send_msg({MSG_NOTE_OFF, 4'h6}, 7'd2, 7'd0);
        // top below bottom
        set_regs(10, 20, 127, 1);
        send_msg({MSG_NOTE_ON, 4'h7}, 7'd50, 7'd1);
        send_msg({MSG_POLY_PRESS, 4'h7}, 7'd15, 7'd2);
        send_msg({MSG_NOTE_OFF, 4'h7}, 7'd50, 7'd0);
    endtask

    // mostly note-on / note-off pairs on held keys, some poly and noise
    task automatic send_random_msg();
        int          pick;
        int          k;
        logic [3:0]  chan;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [7:0]  st;
        pick = $urandom_range(99);
        chan = 4'($urandom_range(15));
        note = 7'($urandom_range(127));
        vel = 7'($urandom_range(127));
        if (held_keys.size() > 24 || (pick >= 35 && pick < 65)) begin
            if (held_keys.size() != 0 && $urandom_range(9) < 8) begin
                k = $urandom_range(held_keys.size() - 1);
                {chan, note} = held_keys[k];
                held_keys.delete(k);
            end
            if ($urandom_range(1)) begin
                st = {MSG_NOTE_OFF, chan};
            end else begin
                st = {MSG_NOTE_ON, chan};
                vel = 7'd0;
            end
        end else if (pick < 35) begin
            st = {MSG_NOTE_ON, chan};
            vel = 7'($urandom_range(127, 1));
            held_keys = {held_keys, {chan, note}};
        end else if (pick < 80) begin
            st = {MSG_POLY_PRESS, chan};
        end else begin
            st = 8'($urandom_range(255));
        end
        send_msg(st, note, vel);
    endtask

    // random phases over settings and idling patterns
    task automatic test_random();
        int top;
        int bottom;
        int shift;
        int pwr;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    top = 127; bottom = 0; shift = 100; pwr = 1;
                end
                1: begin
                    top = 0; bottom = 0; shift = -100; pwr = 1;
                end
                2: begin
                    top = 127; bottom = 126; shift = -128; pwr = 1;
                end
                default: begin
                    top = $urandom_range(127);
                    bottom = ($urandom_range(99) < 85) ? $urandom_range(top) : $urandom_range(127);
                    shift = ($urandom_range(99) < 80) ? $urandom_range(200) - 100
                                                      : $urandom_range(255) - 128;
                    pwr = ($urandom_range(99) < 85) ? 1 : 0;
                end
            endcase
            set_regs(top, bottom, shift, pwr);
            set_idling(t_idle_mode'(ph % 4));
            repeat (100) send_random_msg();
        end
    endtask

    initial begin
        for (int s = 0; s < MEM_DEPTH; s++)
            key_notes[s] = 7'(s / CHANNEL_COUNT);
        set_idling(IDLE_NONE);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_passthrough();
        test_default_fold();
        test_shift_fold();
        test_power_off();
        test_equal_bounds();
        test_fold_limit();
        test_random();

        settle();
        $display("covered %0d messages over %0d register settings and four idling patterns",
                 sent_cnt, settings_cnt);
        $display("%0d results checked, %0d messages dropped at the fold limit",
                 checked_cnt, dropped_cnt);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/mnrf_pkg.sv
rtl/midi_note_range_folder.sv
dv/tb_top.sv
